// ----- hw/rtl/twsa_pkg.sv -----
// Shared types and constants for the timed window sample averager.
// No dependencies; compiled first.
`default_nettype none

package twsa_pkg;

	localparam int SAMPLE_BITS  = 10;
	localparam int COUNT_BITS   = 12;
	localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
	localparam int MS_BITS      = 32;
	localparam int CFG_BITS     = 32;
	localparam int CFG_IDX_BITS = 1;
	localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS);

	localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_PERIOD = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW        = 1'd1;

	localparam logic [MS_BITS-1:0] WINDOW_RESET = MS_BITS'(1000);

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic div_step;
		logic commit;
		logic load_out;
	} twsa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic out_free;
	} twsa_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/twsa_in_if.sv -----
// Input request channel: millisecond time and one converter sample.
// Depends on twsa_pkg.
`default_nettype none

interface twsa_in_if;
	logic                             valid;
	logic                             ready;
	logic [twsa_pkg::MS_BITS-1:0]     now_ms;
	logic [twsa_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, now_ms, sample, input ready);
	modport sink   (input valid, now_ms, sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/twsa_out_if.sv -----
// Result request channel: held average and status flags.
// Depends on twsa_pkg.
`default_nettype none

interface twsa_out_if;
	logic                             valid;
	logic                             ready;
	logic [twsa_pkg::SAMPLE_BITS-1:0] average;
	logic                             has_average;
	logic                             updated;
	logic                             empty_window;

	modport source (output valid, average, has_average, updated, empty_window, input ready);
	modport sink   (input valid, average, has_average, updated, empty_window, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/twsa_datapath.sv -----
// Datapath: configuration, window state, running sum, bit-serial divider
// and output register. Depends on twsa_pkg.
`default_nettype none

module twsa_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [twsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [twsa_pkg::CFG_BITS-1:0]    cfg_data,
	input  wire logic [twsa_pkg::MS_BITS-1:0]     in_now_ms,
	input  wire logic [twsa_pkg::SAMPLE_BITS-1:0] in_sample,
	input  wire twsa_pkg::twsa_cmd_t              cmd,
	output twsa_pkg::twsa_status_t                status,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [twsa_pkg::SAMPLE_BITS-1:0]      out_average,
	output logic                                  out_has_average,
	output logic                                  out_updated,
	output logic                                  out_empty_window
);
	import twsa_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [MS_BITS-1:0]     period_q, window_q;
	logic [MS_BITS-1:0]     last_sample_q, last_window_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [SAMPLE_BITS-1:0] held_q;
	logic                   avg_valid_q, upd_q, emp_q;

	logic [MS_BITS-1:0]     now_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	logic [COUNT_BITS-1:0]  rem_q, dvs_q;
	logic [SAMPLE_BITS-1:0] quo_q;

	logic [MS_BITS-1:0]     elapsed_s, elapsed_w;
	logic                   samp_hit, win_hit, add_ok, pass;
	logic [SUM_BITS-1:0]    sum_nx;
	logic [COUNT_BITS-1:0]  count_nx;
	logic [COUNT_BITS:0]    partial, diff;
	logic                   ge;

	always_comb begin
		elapsed_s = now_q - last_sample_q;
		elapsed_w = now_q - last_window_q;
		samp_hit  = elapsed_s > period_q;
		win_hit   = elapsed_w > window_q;
		pass      = (period_q == '0);
		// a full count drops the sample but still moves the sample time
		add_ok    = samp_hit && (count_q != COUNT_MAX);
		sum_nx    = add_ok ? sum_q + SUM_BITS'(sample_q) : sum_q;
		count_nx  = add_ok ? count_q + COUNT_BITS'(1) : count_q;
		status.need_div = !pass && win_hit && (count_nx != '0);
		status.out_free = !out_valid || out_ready;
	end

	// one quotient bit per step; quotient fits SAMPLE_BITS as sum <= count * max sample
	always_comb begin
		partial = {rem_q, quo_q[SAMPLE_BITS-1]};
		ge      = partial >= {1'b0, dvs_q};
		diff    = partial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= '0;
			window_q      <= WINDOW_RESET;
			last_sample_q <= '0;
			last_window_q <= '0;
			sum_q         <= '0;
			count_q       <= '0;
			held_q        <= '0;
			avg_valid_q   <= 1'b0;
			upd_q         <= 1'b0;
			emp_q         <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SAMPLE_PERIOD: period_q <= cfg_data;
					CFG_WINDOW:        window_q <= cfg_data;
				endcase
			end
			if (cmd.eval) begin
				if (pass) begin
					held_q      <= sample_q;
					avg_valid_q <= 1'b1;
					upd_q       <= 1'b1;
					emp_q       <= 1'b0;
				end else begin
					upd_q <= 1'b0;
					emp_q <= win_hit && (count_nx == '0);
					if (samp_hit)
						last_sample_q <= now_q;
					if (win_hit) begin
						last_window_q <= now_q;
						sum_q         <= '0;
						count_q       <= '0;
					end else begin
						sum_q   <= sum_nx;
						count_q <= count_nx;
					end
				end
			end
			if (cmd.commit) begin
				held_q      <= quo_q;
				avg_valid_q <= 1'b1;
				upd_q       <= 1'b1;
			end
			if (cmd.load_out)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q    <= in_now_ms;
			sample_q <= in_sample;
		end
		if (cmd.eval) begin
			rem_q <= sum_nx[SUM_BITS-1:SAMPLE_BITS];
			quo_q <= sum_nx[SAMPLE_BITS-1:0];
			dvs_q <= count_nx;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : partial[COUNT_BITS-1:0];
			quo_q <= {quo_q[SAMPLE_BITS-2:0], ge};
		end
		if (cmd.load_out) begin
			out_average      <= held_q;
			out_has_average  <= avg_valid_q;
			out_updated      <= upd_q;
			out_empty_window <= emp_q;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/twsa_ctrl.sv -----
// Controller: sequences evaluate, divide and commit if due, then emit.
// Depends on twsa_pkg.
`default_nettype none

module twsa_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire twsa_pkg::twsa_status_t status,
	output twsa_pkg::twsa_cmd_t         cmd
);
	import twsa_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(SAMPLE_BITS - 1);

	logic [2:0]              state_q, state_nx;
	logic [DIV_CNT_BITS-1:0] step_q;
	logic                    in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_fire;
		state_nx     = state_q;
		unique case (state_q)
			S_IDLE:   if (in_fire) state_nx = S_EVAL;
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = status.need_div ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) state_nx = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nx   = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default:  state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DIV)
				step_q <= step_q + DIV_CNT_BITS'(1);
			else
				step_q <= '0;
		end
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_EVAL)
		else $error("accepted request did not move to evaluate");

	a_eval_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> $past(in_fire))
		else $error("evaluate without an accepted request");

	a_commit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |-> $past(state_q) == S_DIV && $past(step_q) == DIV_LAST)
		else $error("commit before divider finished");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> step_q <= DIV_LAST)
		else $error("divider step count out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/timed_window_sample_averager_core.sv -----
// Timed window sample averager: top level joining controller and datapath.
// Depends on twsa_pkg, twsa_in_if, twsa_out_if, twsa_ctrl, twsa_datapath.
//
// Usage:
//   in_ch carries now_ms (free-running ms time) and one sample per request;
//   out_ch returns exactly one result per request: held average, has_average,
//   updated and empty_window. Configuration (sample period, window length)
//   is written through cfg_we / cfg_index / cfg_data while idle.
// Timing:
//   A request is taken when the block is idle. An ordinary request steps
//   through accept, evaluate and load output register; the next request is
//   not taken until the block is back in idle. A request that closes a
//   non-empty window runs the bit-serial divider, one quotient bit per cycle,
//   then a commit step before the output register is loaded.
// Stall:
//   The output register holds a result until taken; the next request is
//   accepted meanwhile and waits in its emit step until the register frees.
// Reset:
//   arst_n clears sums, counts, times and the held average, sets the sample
//   period to 0 (pass-through) and the window to 1000 ms.
`default_nettype none

module timed_window_sample_averager_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [twsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [twsa_pkg::CFG_BITS-1:0]     cfg_data,
	twsa_in_if.sink                                in_ch,
	twsa_out_if.source                             out_ch
);
	import twsa_pkg::*;

	twsa_cmd_t    cmd;
	twsa_status_t status;

	twsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	twsa_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_now_ms        (in_ch.now_ms),
		.in_sample        (in_ch.sample),
		.cmd              (cmd),
		.status           (status),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_average      (out_ch.average),
		.out_has_average  (out_ch.has_average),
		.out_updated      (out_ch.updated),
		.out_empty_window (out_ch.empty_window)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for timed_window_sample_averager_core.
// Needs twsa_pkg, twsa_in_if, twsa_out_if and the core RTL; predicts each
// result in-line and checks each result against it under random back-pressure.
`timescale 1ns / 1ps

module tb_top;
	import twsa_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_FILL = 60;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] average;
		logic                   has_average;
		logic                   updated;
		logic                   empty_window;
	} avg_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	twsa_in_if  in_ch();
	twsa_out_if out_ch();

	timed_window_sample_averager_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// predictor copy of configuration and state
	logic [MS_BITS-1:0]     period_ms;
	logic [MS_BITS-1:0]     window_len_ms;
	logic [MS_BITS-1:0]     last_smp_ms;
	logic [MS_BITS-1:0]     last_win_ms;
	logic [SUM_BITS-1:0]    smp_sum;
	logic [COUNT_BITS-1:0]  smp_cnt;
	logic [SAMPLE_BITS-1:0] held_avg;
	logic                   held_avg_ok;

	avg_result_t pending_avgs[$];
	avg_result_t want;
	logic [MS_BITS-1:0] clock_ms;

	int fails;
	int n_results;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic avg_result_t predict_average(input logic [MS_BITS-1:0] now,
			input logic [SAMPLE_BITS-1:0] smp);
		avg_result_t r;
		logic [MS_BITS-1:0] since;
		r.updated = 1'b0;
		r.empty_window = 1'b0;
		if (period_ms == '0) begin
			held_avg = smp;
			held_avg_ok = 1'b1;
			r.updated = 1'b1;
		end else begin
			since = now - last_smp_ms;
			if (since > period_ms) begin
				last_smp_ms = now;
				// full count: sample dropped, time still moves
				if (smp_cnt != '1) begin
					smp_sum = smp_sum + SUM_BITS'(smp);
					smp_cnt = smp_cnt + COUNT_BITS'(1);
				end
			end
			since = now - last_win_ms;
			if (since > window_len_ms) begin
				last_win_ms = now;
				if (smp_cnt != '0) begin
					held_avg = SAMPLE_BITS'(smp_sum / SUM_BITS'(smp_cnt));
					held_avg_ok = 1'b1;
					r.updated = 1'b1;
				end else begin
					r.empty_window = 1'b1;
				end
				smp_sum = '0;
				smp_cnt = '0;
			end
		end
		r.average = held_avg;
		r.has_average = held_avg_ok;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		$display("mismatch on result %0d: %s expected %0d got %0d",
			n_results, what, exp_v, got_v);
		fails++;
	endtask

	// check first, then record the new request, so order within the edge is fixed
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_avgs.size() == 0) begin
				report_mismatch("unexpected result, nothing pending", 0, 0);
			end else begin
				want = pending_avgs.pop_front();
				if (out_ch.average !== want.average)
					report_mismatch("average", 32'(want.average), 32'(out_ch.average));
				if (out_ch.has_average !== want.has_average)
					report_mismatch("has_average", 32'(want.has_average),
						32'(out_ch.has_average));
				if (out_ch.updated !== want.updated)
					report_mismatch("updated", 32'(want.updated), 32'(out_ch.updated));
				if (out_ch.empty_window !== want.empty_window)
					report_mismatch("empty_window", 32'(want.empty_window),
						32'(out_ch.empty_window));
			end
			n_results++;
		end
		if (arst_n && in_ch.valid && in_ch.ready)
			pending_avgs.push_back(predict_average(in_ch.now_ms, in_ch.sample));
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// called and returns at a falling edge; valid is left high for the next request
	task automatic send_req(input logic [MS_BITS-1:0] now, input logic [SAMPLE_BITS-1:0] smp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.now_ms <= now;
		in_ch.sample <= smp;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic tick(input logic [MS_BITS-1:0] step, input logic [SAMPLE_BITS-1:0] smp);
		clock_ms = clock_ms + step;
		send_req(clock_ms, smp);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (pending_avgs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_SAMPLE_PERIOD)
			period_ms = val;
		else
			window_len_ms = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_no_average_yet();
		cfg_write(CFG_SAMPLE_PERIOD, 32'd5);
		cfg_write(CFG_WINDOW, 32'd20);
		tick(32'd0, 10'd1023);
		tick(32'd3, 10'd1023);
		tick(32'd3, 10'd1023);
		tick(32'd15, 10'd0);
		tick(32'd4, 10'd77);
		wait_drain();
	endtask

	task automatic test_empty_window();
		cfg_write(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
		cfg_write(CFG_WINDOW, 32'd0);
		tick(32'd1, 10'd300);
		tick(32'd0, 10'd300);
		tick(32'd7, 10'd1);
		wait_drain();
		cfg_write(CFG_WINDOW, 32'hFFFF_FFFF);
		tick($urandom, 10'd5);
		tick($urandom, 10'd6);
		wait_drain();
	endtask

	task automatic test_pass_through();
		cfg_write(CFG_SAMPLE_PERIOD, 32'd0);
		cfg_write(CFG_WINDOW, 32'd0);
		clock_ms = '0;
		tick(32'd0, 10'd0);
		tick(32'hFFFF_FFFF, 10'd1023);
		tick(32'd0, 10'h2AA);
		tick(32'd1, 10'h155);
		wait_drain();
	endtask

	task automatic test_wraparound();
		cfg_write(CFG_SAMPLE_PERIOD, 32'd10);
		cfg_write(CFG_WINDOW, 32'd100);
		clock_ms = 32'hFFFF_FFA0;
		repeat (12) tick(32'd11, 10'($urandom));
		wait_drain();
	endtask

	// build a large sum with a window that never closes, then close it
	task automatic test_long_window();
		cfg_write(CFG_SAMPLE_PERIOD, 32'd1);
		cfg_write(CFG_WINDOW, 32'hFFFF_FFFF);
		repeat (LONG_FILL) tick(32'd2, 10'($urandom_range(900, 1023)));
		wait_drain();
		cfg_write(CFG_WINDOW, 32'd0);
		tick(32'd2, 10'd1023);
		tick(32'd2, 10'd1023);
		wait_drain();
	endtask

	task automatic test_random(input int s_pct, input int r_pct, input int n_items);
		logic [MS_BITS-1:0] step;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				wait_drain();
				case ($urandom_range(0, 5))
					0: cfg_write(CFG_SAMPLE_PERIOD, 32'd0);
					1: cfg_write(CFG_SAMPLE_PERIOD, 32'd1);
					2: cfg_write(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
					3: cfg_write(CFG_SAMPLE_PERIOD, $urandom);
					default: cfg_write(CFG_SAMPLE_PERIOD, $urandom_range(1, 15));
				endcase
				case ($urandom_range(0, 5))
					0: cfg_write(CFG_WINDOW, 32'd0);
					1: cfg_write(CFG_WINDOW, 32'd1000);
					2: cfg_write(CFG_WINDOW, 32'hFFFF_FFFF);
					3: cfg_write(CFG_WINDOW, $urandom);
					default: cfg_write(CFG_WINDOW, $urandom_range(0, 60));
				endcase
				if ($urandom_range(0, 3) == 0)
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
			end
			case ($urandom_range(0, 9))
				0: step = '0;
				1: step = $urandom;
				7, 8: step = $urandom_range(0, 80);
				9: step = $urandom_range(900, 1100);
				default: step = $urandom_range(0, 12);
			endcase
			tick(step, 10'($urandom));
			// hold off now and then until every result is back
			if ($urandom_range(0, 99) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.now_ms = '0;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		period_ms = '0;
		window_len_ms = WINDOW_RESET;
		last_smp_ms = '0;
		last_win_ms = '0;
		smp_sum = '0;
		smp_cnt = '0;
		held_avg = '0;
		held_avg_ok = 1'b0;
		clock_ms = '0;
		fails = 0;
		n_results = 0;
		quiet_cycles = 0;
		send_idle_pct = 14;
		recv_idle_pct = 51;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_no_average_yet();
		test_empty_window();
		test_pass_through();
		test_wraparound();
		test_long_window();
		test_random(14, 51, 220);
		test_random(51, 14, 220);
		test_random(0, 0, 220);

		wait_drain();
		if (pending_avgs.size() != 0)
			report_mismatch("results still pending at end", 0, pending_avgs.size());
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/twsa_pkg.sv
hw/rtl/twsa_in_if.sv
hw/rtl/twsa_out_if.sv
hw/rtl/twsa_datapath.sv
hw/rtl/twsa_ctrl.sv
hw/rtl/timed_window_sample_averager_core.sv
tb/tb_top.sv
